@@ sv/polygon_plane_clipper_macros.svh @@
// ----------------------------------------------------------------------------
// Polygon plane clipper assertion macros
// Concurrent check helpers shared by the clipper modules.
// ----------------------------------------------------------------------------
`ifndef POLYGON_PLANE_CLIPPER_MACROS_SVH
`define POLYGON_PLANE_CLIPPER_MACROS_SVH

`ifndef SYNTHESIS
// check an implication on every clock edge out of reset
`define PPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// check a condition that must hold on every clock edge out of reset
`define PPC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`else
`define PPC_ASSERT_IMP(lbl, ante, cons, msg)
`define PPC_ASSERT_ALWAYS(lbl, cond, msg)
`endif

`endif

@@ sv/ppc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon plane clipper package
// Shared types, constants and vertex helpers.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int VERTEX_DIM  = 7;
    localparam int MAX_EDGES   = 64;
    localparam int CAP_INT     = (2 * MAX_EDGES < 255) ? 2 * MAX_EDGES : 255;
    localparam logic [7:0] COUNT_CAP = 8'(CAP_INT);
    localparam int ATTR_INT    = (VERTEX_DIM - 3 < 4) ? VERTEX_DIM - 3 : 4;
    localparam logic [2:0] ATTR_LIMIT = 3'(ATTR_INT);

    localparam int SLAB_FULL = 15;
    localparam int SLAB_HI   = 14;
    localparam int SLAB_LO   = 7;
    localparam int NEAR_P    = 8;
    localparam int DIV_BITS  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [2:0] COMP_X = 3'd0;
    localparam logic [2:0] COMP_Y = 3'd1;
    localparam logic [2:0] COMP_Z = 3'd2;
    localparam logic [2:0] COMP_A = 3'd3;
    localparam logic [2:0] COMP_B = 3'd4;
    localparam logic [2:0] COMP_C = 3'd5;
    localparam logic [2:0] COMP_D = 3'd6;

    typedef enum logic [2:0] {
        CFG_AXIS_MODE  = 3'd0,
        CFG_CLIP_MIN   = 3'd1,
        CFG_CLIP_MAX   = 3'd2,
        CFG_ATTR_COUNT = 3'd3,
        CFG_NEAR_PLANE = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV_GO,
        B_DIV_WAIT,
        B_LERP,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]         axis_mode;
        logic signed [15:0] clip_min;
        logic signed [15:0] clip_max;
        logic [2:0]         attr_count;
        logic [15:0]        near_plane;
    } cfg_t;

    typedef struct packed {
        logic [3:0][23:0]   attr;
        logic signed [23:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } vtx_t;

    typedef struct packed {
        vtx_t s;
        vtx_t e;
        logic lo_start;
        logic clip_lo;
        logic clip_hi;
        logic emit_s;
        logic emit_e;
        logic last;
    } job_t;

    typedef struct packed {
        vtx_t       v;
        logic       is_closing;
        logic       end_of_run;
        logic [7:0] vertex_count;
    } out_t;

    function automatic logic signed [23:0] vtx_comp(vtx_t v, logic [2:0] k);
        logic signed [23:0] r;
        case (k)
            COMP_X:  r = 24'(v.x);
            COMP_Y:  r = 24'(v.y);
            COMP_Z:  r = v.z;
            COMP_A:  r = v.attr[0];
            COMP_B:  r = v.attr[1];
            COMP_C:  r = v.attr[2];
            COMP_D:  r = v.attr[3];
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic vtx_t vtx_set(vtx_t v, logic [2:0] k, logic [23:0] val);
        vtx_t r;
        r = v;
        case (k)
            COMP_X:  r.x = val[15:0];
            COMP_Y:  r.y = val[15:0];
            COMP_Z:  r.z = val;
            COMP_A:  r.attr[0] = val;
            COMP_B:  r.attr[1] = val;
            COMP_C:  r.attr[2] = val;
            COMP_D:  r.attr[3] = val;
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

@@ sv/ppc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipper front end
// Accepts vertices, keeps the previous one and classifies each edge.
// ----------------------------------------------------------------------------
module ppc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  ppc_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  ppc_pkg::vtx_t in_vtx,
    input  logic          in_last,
    input  logic          q_full,
    output logic          push,
    output ppc_pkg::job_t push_job
);
    import ppc_pkg::*;

    vtx_t prev_reg;
    logic have_prev_reg;

    logic [2:0]         n_attr;
    vtx_t               cur_v;
    vtx_t               prv_v;
    logic               slab;
    logic [2:0]         sel;
    logic signed [23:0] s_c;
    logic signed [23:0] e_c;
    logic signed [23:0] lo_c;
    logic signed [23:0] hi_c;
    logic signed [23:0] bnd_min;
    logic signed [23:0] bnd_max;
    logic signed [23:0] near_z;
    logic               lo_start;
    logic               drop;
    logic               clip_lo;
    logic               clip_hi;
    logic               edge_ok;

    always_comb
    begin
        n_attr = (cfg.attr_count > ATTR_LIMIT) ? ATTR_LIMIT : cfg.attr_count;
        cur_v  = in_vtx;
        prv_v  = prev_reg;
        // zero attributes that are not in use on both ends
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) >= n_attr)
            begin
                cur_v.attr[i] = '0;
                prv_v.attr[i] = '0;
            end
        end
        slab     = (cfg.axis_mode == AXIS_X) || (cfg.axis_mode == AXIS_Y);
        sel      = slab ? ((cfg.axis_mode == AXIS_Y) ? COMP_Y : COMP_X) : COMP_Z;
        s_c      = vtx_comp(prv_v, sel);
        e_c      = vtx_comp(cur_v, sel);
        lo_start = s_c < e_c;
        lo_c     = lo_start ? s_c : e_c;
        hi_c     = lo_start ? e_c : s_c;
        bnd_min  = 24'(cfg.clip_min);
        bnd_max  = 24'(cfg.clip_max);
        near_z   = {8'd0, cfg.near_plane};
        if (slab)
        begin
            drop    = (lo_c >= bnd_max) || (hi_c <= bnd_min);
            clip_lo = lo_c <= bnd_min;
            clip_hi = hi_c >= bnd_max;
        end
        else
        begin
            drop    = hi_c < near_z;
            clip_lo = lo_c < near_z;
            clip_hi = 1'b0;
        end
        edge_ok = have_prev_reg && !drop;

        push_job.s        = prv_v;
        push_job.e        = cur_v;
        push_job.lo_start = lo_start;
        push_job.clip_lo  = edge_ok && clip_lo;
        push_job.clip_hi  = edge_ok && clip_hi;
        push_job.emit_s   = edge_ok && (lo_start ? clip_lo : clip_hi);
        push_job.emit_e   = edge_ok;
        push_job.last     = in_last;
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
        end
        else if (push)
        begin
            have_prev_reg <= !in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            prev_reg <= cur_v;
        end
    end

endmodule

@@ sv/ppc_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipper job queue
// Short queue of classified edges between front and back end.
// ----------------------------------------------------------------------------
`include "polygon_plane_clipper_macros.svh"

module ppc_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ppc_pkg::job_t push_job,
    input  logic          pop,
    output ppc_pkg::job_t head,
    output logic          full,
    output logic          empty
);
    import ppc_pkg::*;

    // depth is a power of two, so pointers wrap on their own
    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full  = cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `PPC_ASSERT_IMP(a_pop_nonempty, pop, !empty, "queue popped while empty")

endmodule

@@ sv/ppc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipper serial divider
// Restoring divide, one quotient bit per cycle, quotient below 2^16.
// ----------------------------------------------------------------------------
module ppc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [23:0] den,
    output logic        done,
    output logic [15:0] quot
);
    import ppc_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic [23:0]          rem_reg;
    logic [23:0]          den_reg;
    logic [DIV_BITS-1:0]  lo_reg;
    logic [DIV_BITS-1:0]  quot_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 done_reg;

    logic [24:0] trial;
    logic [24:0] diff;
    logic        ge;

    always_comb
    begin
        trial = {rem_reg, lo_reg[DIV_BITS-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DIV_BITS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= cnt_reg == CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // high half is below the divisor, so the quotient fits
            rem_reg <= 24'(num[31:DIV_BITS]);
            lo_reg  <= num[DIV_BITS-1:0];
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= ge ? diff[23:0] : trial[23:0];
            lo_reg   <= {lo_reg[DIV_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_BITS-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ sv/ppc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipper back end
// Computes clipped endpoints and hands out the resulting vertices.
// ----------------------------------------------------------------------------
`include "polygon_plane_clipper_macros.svh"

module ppc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ppc_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  ppc_pkg::job_t q_head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output ppc_pkg::out_t out_item
);
    import ppc_pkg::*;

    localparam logic [1:0] STEP_START = 2'd0;
    localparam logic [1:0] STEP_END   = 2'd1;
    localparam logic [1:0] STEP_CLOSE = 2'd2;
    localparam logic [3:0] LERP_LAST  = 4'd8;
    localparam logic [3:0] LERP_COMPS = 4'd7;

    back_state_t state_reg;
    back_state_t state_next;

    job_t        job_reg;
    vtx_t        sv_reg;
    vtx_t        ev_reg;
    vtx_t        first_reg;
    logic        pass_reg;
    logic [15:0] q_reg;
    logic [3:0]  k_reg;
    logic [1:0]  step_reg;
    logic [7:0]  count_reg;
    logic        out_valid_reg;
    out_t        out_reg;

    logic signed [24:0] d1_reg;
    logic [15:0]        tm1_reg;
    logic [3:0]         sh1_reg;
    logic signed [23:0] b1_reg;
    logic               rp1_reg;
    logic               v1_reg;
    logic [2:0]         i1_reg;

    logic signed [41:0] p2_reg;
    logic [3:0]         sh2_reg;
    logic signed [23:0] b2_reg;
    logic               rp2_reg;
    logic               v2_reg;
    logic [2:0]         i2_reg;

    // shared terms
    logic               slab;
    logic [2:0]         c_sel;
    vtx_t               lv;
    vtx_t               rv;
    logic signed [23:0] bound;
    logic signed [23:0] bound_val;
    logic signed [24:0] lc;
    logic signed [24:0] rc;
    logic signed [24:0] lz;
    logic signed [24:0] rz;
    logic signed [24:0] bdiff;
    logic signed [24:0] zdiff;
    logic signed [24:0] sdiff;
    logic signed [24:0] ddiff;
    logic [31:0]        div_num;
    logic [23:0]        div_den;
    logic               div_start;
    logic               div_done;
    logic [15:0]        div_quot;

    // interpolation stage one
    logic [2:0]         k3;
    logic signed [23:0] lk;
    logic signed [24:0] dk;
    logic signed [24:0] d1;
    logic [15:0]        tm1;
    logic [3:0]         sh1;
    logic               rp1;

    // interpolation stage three
    logic signed [41:0] shifted;
    logic signed [42:0] sum3;
    logic [23:0]        sat3;
    logic [23:0]        val3;
    logic               tgt_s;

    // emission
    logic       present;
    logic       out_free;
    logic       emit_load;
    logic       emit_adv;
    logic       emit_fin;
    logic [7:0] count_inc;
    out_t       item;

    always_comb
    begin
        slab      = (cfg.axis_mode == AXIS_X) || (cfg.axis_mode == AXIS_Y);
        c_sel     = (cfg.axis_mode == AXIS_Y) ? COMP_Y : COMP_X;
        lv        = job_reg.lo_start ? job_reg.s : job_reg.e;
        rv        = job_reg.lo_start ? job_reg.e : job_reg.s;
        bound     = pass_reg ? 24'(cfg.clip_max) : 24'(cfg.clip_min);
        bound_val = slab ? bound : {8'd0, cfg.near_plane};
        lc        = 25'(vtx_comp(lv, c_sel));
        rc        = 25'(vtx_comp(rv, c_sel));
        lz        = 25'(vtx_comp(lv, COMP_Z));
        rz        = 25'(vtx_comp(rv, COMP_Z));
        bdiff     = 25'(bound) - lc;
        sdiff     = rc - lc;
        zdiff     = $signed({9'd0, cfg.near_plane}) - lz;
        ddiff     = rz - lz;
        if (slab)
        begin
            div_num = 32'(bdiff[16:0]) << SLAB_FULL;
            div_den = 24'(sdiff[16:0]);
        end
        else
        begin
            div_num = 32'(zdiff[23:0]) << NEAR_P;
            div_den = ddiff[23:0];
        end
    end

    ppc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // stage one: pick difference, weight and shift for component k
    always_comb
    begin
        k3  = k_reg[2:0];
        lk  = vtx_comp(lv, k3);
        dk  = 25'(vtx_comp(rv, k3)) - 25'(lk);
        d1  = dk;
        tm1 = q_reg;
        sh1 = '0;
        rp1 = 1'b0;
        if (slab)
        begin
            if (k3 == c_sel)
            begin
                rp1 = 1'b1;
            end
            else if (k3 == COMP_Z)
            begin
                sh1 = 4'(SLAB_FULL);
            end
            else if (k3 < COMP_Z)
            begin
                tm1 = q_reg >> (SLAB_FULL - SLAB_HI);
                sh1 = 4'(SLAB_HI);
            end
            else
            begin
                tm1 = q_reg >> (SLAB_FULL - SLAB_HI + SLAB_LO);
                d1  = dk >>> SLAB_LO;
            end
        end
        else
        begin
            if (k3 == COMP_Z)
            begin
                rp1 = 1'b1;
            end
            else
            begin
                sh1 = 4'(NEAR_P);
            end
        end
    end

    // stage three: floor shift, add base, saturate to 24 bits, or take the bound
    always_comb
    begin
        shifted = p2_reg >>> sh2_reg;
        sum3    = 43'(b2_reg) + 43'(shifted);
        if (sum3 > 43'sd8388607)
        begin
            sat3 = 24'h7FFFFF;
        end
        else if (sum3 < -43'sd8388608)
        begin
            sat3 = 24'h800000;
        end
        else
        begin
            sat3 = sum3[23:0];
        end
        val3  = rp2_reg ? bound_val : sat3;
        tgt_s = pass_reg ? !job_reg.lo_start : job_reg.lo_start;
    end

    // emission selection
    always_comb
    begin
        out_free  = !out_valid_reg || out_ready;
        count_inc = (count_reg < COUNT_CAP) ? count_reg + 8'd1 : count_reg;
        case (step_reg)
            STEP_START:
            begin
                present           = job_reg.emit_s;
                item.v            = sv_reg;
                item.is_closing   = 1'b0;
                item.end_of_run   = !(job_reg.emit_e || job_reg.last);
                item.vertex_count = count_inc;
            end
            STEP_END:
            begin
                present           = job_reg.emit_e;
                item.v            = ev_reg;
                item.is_closing   = 1'b0;
                item.end_of_run   = !job_reg.last;
                item.vertex_count = count_inc;
            end
            default:
            begin
                present           = job_reg.last && (count_reg != '0);
                item.v            = first_reg;
                item.is_closing   = 1'b1;
                item.end_of_run   = 1'b1;
                item.vertex_count = count_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_head.clip_lo || q_head.clip_hi) ? B_DIV_GO : B_EMIT;
                end
            end
            B_DIV_GO:
            begin
                state_next = B_DIV_WAIT;
            end
            B_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = B_LERP;
                end
            end
            B_LERP:
            begin
                if (k_reg == LERP_LAST)
                begin
                    state_next = (!pass_reg && job_reg.clip_hi) ? B_DIV_GO : B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (emit_fin)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop       = (state_reg == B_IDLE) && !q_empty;
        div_start = state_reg == B_DIV_GO;
        emit_adv  = (state_reg == B_EMIT) && (!present || out_free);
        emit_load = (state_reg == B_EMIT) && present && out_free;
        emit_fin  = emit_adv && (step_reg == STEP_CLOSE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            step_reg      <= STEP_START;
            k_reg         <= '0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == B_LERP) && (k_reg < LERP_COMPS);
            v2_reg    <= v1_reg;
            if (pop)
            begin
                pass_reg <= !q_head.clip_lo;
                step_reg <= STEP_START;
            end
            if (div_done)
            begin
                k_reg <= '0;
            end
            else if (state_reg == B_LERP)
            begin
                k_reg <= k_reg + 4'd1;
                if (k_reg == LERP_LAST)
                begin
                    pass_reg <= 1'b1;
                end
            end
            if (emit_adv)
            begin
                step_reg <= step_reg + 2'd1;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
                if (step_reg != STEP_CLOSE)
                begin
                    count_reg <= count_inc;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // a polygon ends: start counting afresh
            if (emit_fin && job_reg.last)
            begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_head;
            sv_reg  <= q_head.s;
            ev_reg  <= q_head.e;
        end
        else if (v2_reg)
        begin
            if (tgt_s)
            begin
                sv_reg <= vtx_set(sv_reg, i2_reg, val3);
            end
            else
            begin
                ev_reg <= vtx_set(ev_reg, i2_reg, val3);
            end
        end
        if (div_done)
        begin
            q_reg <= div_quot;
        end
        d1_reg  <= d1;
        tm1_reg <= tm1;
        sh1_reg <= sh1;
        b1_reg  <= lk;
        rp1_reg <= rp1;
        i1_reg  <= k3;
        p2_reg  <= $signed({1'b0, tm1_reg}) * d1_reg;
        sh2_reg <= sh1_reg;
        b2_reg  <= b1_reg;
        rp2_reg <= rp1_reg;
        i2_reg  <= i1_reg;
        if (emit_load)
        begin
            out_reg <= item;
            if ((step_reg != STEP_CLOSE) && (count_reg == '0))
            begin
                first_reg <= item.v;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    `PPC_ASSERT_IMP(a_div_done_wait, div_done, state_reg == B_DIV_WAIT, "divide done out of turn")
    `PPC_ASSERT_IMP(a_div_quot_range, div_done, div_quot <= 16'h8000, "clip weight above one")
    `PPC_ASSERT_ALWAYS(a_count_cap, count_reg <= COUNT_CAP, "vertex count past cap")

endmodule

@@ sv/polygon_plane_clipper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon plane clipper
// Sutherland-Hodgman clip of one polygon against an x or y slab or the near z plane.
// ----------------------------------------------------------------------------
// Vertices stream in one beat each, the polygon's first vertex repeated as the
// closing beat with tlast set; every beat after the first clips the edge from
// the previous vertex against the x or y slab or the near z plane and yields
// zero to two vertices, and the closing beat adds a copy of the first output
// vertex flagged in tuser. Each clipped endpoint takes a pass of the 16-step
// serial divider and of the shared interpolation multiplier. A two-entry queue
// lets input beats be taken while the back end works. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module polygon_plane_clipper (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, attr_a, attr_b, attr_c, attr_d
    input  logic [151:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, out_attr_a, out_attr_b, out_attr_c, out_attr_d,
    // vertex_count
    output logic [159:0] m_axis_tdata,
    // is_closing
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import ppc_pkg::*;

    cfg_t cfg_reg;
    vtx_t in_vtx;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t q_head;
    out_t out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_mode  <= AXIS_X;
            cfg_reg.clip_min   <= 16'sd0;
            cfg_reg.clip_max   <= 16'sd319;
            cfg_reg.attr_count <= 3'd4;
            cfg_reg.near_plane <= 16'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AXIS_MODE:  cfg_reg.axis_mode  <= cfg_data[1:0];
                CFG_CLIP_MIN:   cfg_reg.clip_min   <= cfg_data;
                CFG_CLIP_MAX:   cfg_reg.clip_max   <= cfg_data;
                CFG_ATTR_COUNT: cfg_reg.attr_count <= cfg_data[2:0];
                CFG_NEAR_PLANE: cfg_reg.near_plane <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_vtx.x       = s_axis_tdata[15:0];
        in_vtx.y       = s_axis_tdata[31:16];
        in_vtx.z       = s_axis_tdata[55:32];
        in_vtx.attr[0] = s_axis_tdata[79:56];
        in_vtx.attr[1] = s_axis_tdata[103:80];
        in_vtx.attr[2] = s_axis_tdata[127:104];
        in_vtx.attr[3] = s_axis_tdata[151:128];
    end

    ppc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_vtx   (in_vtx),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    ppc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    ppc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {out_item.vertex_count, out_item.v.attr[3], out_item.v.attr[2],
                           out_item.v.attr[1], out_item.v.attr[0], out_item.v.z,
                           out_item.v.y, out_item.v.x};
    assign m_axis_tuser = out_item.is_closing;
    assign m_axis_tlast = out_item.end_of_run;

endmodule

@@ test/tb_polygon_plane_clipper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon plane clipper testbench
// Streams polygons through the clipper under random source gaps and sink
// stalls. A behavioral copy of the edge clip computes the expected vertex
// beats, and each output beat is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_polygon_plane_clipper;
    import ppc_pkg::*;

    typedef longint vec_t [7];
    typedef struct {
        logic [159:0] data;
        bit           closing;
        bit           last;
    } beat_t;

    localparam int RUN_LIMIT = 400000;
    localparam int SETTLE    = 200;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;

    polygon_plane_clipper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clip settings as the block holds them
    logic [1:0] plane_axis;
    longint     slab_lo;
    longint     slab_hi;
    int         attr_used;
    longint     near_z;

    // edge state
    vec_t       last_vtx;
    bit         open_edge;
    vec_t       first_emitted;
    int         poly_count;

    beat_t      pending_beats[$];
    int         errors;
    int         items_sent;
    int         cycles;
    int         burst_left;
    bit         src_gaps;
    bit         stall_request;
    int         stall_left;
    int         rx_mode;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint clamp24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic void slab_cut(input vec_t lo, input vec_t hi, inout vec_t o,
                                     input int len, input longint bound, input int c);
        longint unsigned num;
        longint unsigned den;
        longint t15;
        longint t14;
        longint t7;
        int oc;
        oc  = 1 - c;
        num = longint'(bound - lo[c]) << SLAB_FULL;
        den = longint'(hi[c] - lo[c]);
        t15 = longint'(num / den);
        t14 = t15 >>> 1;
        t7  = t14 >>> SLAB_LO;
        for (int i = 3; i < len; i++)
            o[i] = clamp24(lo[i] + t7 * ((hi[i] - lo[i]) >>> SLAB_LO));
        o[2]  = lo[2] + ((t15 * (hi[2] - lo[2])) >>> SLAB_FULL);
        o[c]  = bound;
        o[oc] = lo[oc] + ((t14 * (hi[oc] - lo[oc])) >>> SLAB_HI);
    endfunction

    // -1 drop, 0 end only, 1 start then end
    function automatic int clip_slab(inout vec_t s, inout vec_t e, input int len,
                                     input int c);
        vec_t lo;
        vec_t hi;
        bit   lo_start;
        int   r;
        lo_start = s[c] < e[c];
        if (lo_start)
        begin
            lo = s;
            hi = e;
        end
        else
        begin
            lo = e;
            hi = s;
        end
        if (lo[c] >= slab_hi || hi[c] <= slab_lo)
            return -1;
        r = 0;
        if (lo[c] <= slab_lo)
        begin
            if (lo_start)
            begin
                r = 1;
                slab_cut(lo, hi, s, len, slab_lo, c);
            end
            else
                slab_cut(lo, hi, e, len, slab_lo, c);
        end
        if (hi[c] >= slab_hi)
        begin
            if (lo_start)
                slab_cut(lo, hi, e, len, slab_hi, c);
            else
            begin
                r = 1;
                slab_cut(lo, hi, s, len, slab_hi, c);
            end
        end
        return r;
    endfunction

    function automatic int clip_near(inout vec_t s, inout vec_t e, input int len);
        vec_t   lo;
        vec_t   hi;
        vec_t   w;
        bit     lo_start;
        longint t;
        lo_start = s[2] < e[2];
        if (lo_start)
        begin
            lo = s;
            hi = e;
        end
        else
        begin
            lo = e;
            hi = s;
        end
        if (hi[2] < near_z)
            return -1;
        if (lo[2] >= near_z)
            return 0;
        t = longint'((longint'(near_z - lo[2]) << NEAR_P) / longint'(hi[2] - lo[2]));
        w = lo;
        for (int i = 0; i < len; i++)
            w[i] = lo[i] + ((t * (hi[i] - lo[i])) >>> NEAR_P);
        w[2] = near_z;
        if (lo_start)
        begin
            s = w;
            return 1;
        end
        e = w;
        return 0;
    endfunction

    function automatic beat_t make_beat(vec_t v, bit closing, int count);
        beat_t b;
        b.data = {8'(count), 24'(v[6]), 24'(v[5]), 24'(v[4]), 24'(v[3]), 24'(v[2]),
                  16'(v[1]), 16'(v[0])};
        b.closing = closing;
        b.last    = 1'b0;
        return b;
    endfunction

    function automatic void record_vertex(vec_t v, inout beat_t res[$]);
        if (poly_count == 0)
            first_emitted = v;
        if (poly_count < int'(COUNT_CAP))
            poly_count++;
        res.push_back(make_beat(v, 1'b0, poly_count));
    endfunction

    function automatic void predict_clip(vec_t in_v, bit closing_vtx);
        vec_t  cur;
        vec_t  s;
        vec_t  e;
        beat_t res[$];
        int    len;
        int    r;
        len = 3 + ((attr_used > 4) ? 4 : attr_used);
        // take the fields as the port carries them
        for (int i = 0; i < 7; i++)
            cur[i] = (i < 2) ? longint'($signed(16'(in_v[i])))
                             : longint'($signed(24'(in_v[i])));
        for (int i = len; i < 7; i++)
            cur[i] = 0;
        if (open_edge)
        begin
            s = last_vtx;
            for (int i = len; i < 7; i++)
                s[i] = 0;
            e = cur;
            if (plane_axis == AXIS_X || plane_axis == AXIS_Y)
                r = clip_slab(s, e, len, int'(plane_axis));
            else
                r = clip_near(s, e, len);
            if (r == 1)
                record_vertex(s, res);
            if (r >= 0)
                record_vertex(e, res);
        end
        last_vtx  = cur;
        open_edge = 1'b1;
        if (closing_vtx)
        begin
            if (poly_count > 0)
                res.push_back(make_beat(first_emitted, 1'b1, poly_count));
            open_edge  = 1'b0;
            poly_count = 0;
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            pending_beats.push_back(res[i]);
    endfunction

    // ---------------------------------------------------------------- checker
    string fld_name [8] = '{"out_x", "out_y", "out_z", "out_attr_a", "out_attr_b",
                            "out_attr_c", "out_attr_d", "vertex_count"};
    int    fld_lo   [8] = '{0, 16, 32, 56, 80, 104, 128, 152};
    int    fld_w    [8] = '{16, 16, 24, 24, 24, 24, 24, 8};

    always @(posedge clk)
    begin
        beat_t        want;
        logic [159:0] mask;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat data=%h", $time, m_axis_tdata);
            end
            else
            begin
                want = pending_beats.pop_front();
                for (int f = 0; f < 8; f++)
                begin
                    mask = (160'd1 << fld_w[f]) - 1;
                    if (((want.data >> fld_lo[f]) & mask) !=
                        ((m_axis_tdata >> fld_lo[f]) & mask))
                    begin
                        errors++;
                        $display("%0t: %s expected %h actual %h", $time, fld_name[f],
                                 (want.data >> fld_lo[f]) & mask,
                                 (m_axis_tdata >> fld_lo[f]) & mask);
                    end
                end
                if (want.closing != m_axis_tuser[0])
                begin
                    errors++;
                    $display("%0t: is_closing expected %0d actual %0d", $time,
                             want.closing, m_axis_tuser[0]);
                end
                if (want.last != m_axis_tlast)
                begin
                    errors++;
                    $display("%0t: end_of_run expected %0d actual %0d", $time,
                             want.last, m_axis_tlast);
                end
            end
        end
    end

    // sink: the stall pattern is redrawn at random; long hold-off on request
    always @(posedge clk)
    begin
        if (cycles % 64 == 0)
            rx_mode <= $urandom_range(0, 2);
        if (stall_request)
        begin
            stall_request = 1'b0;
            stall_left    = 600;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_mode == 0)
            m_axis_tready <= 1'b1;
        else if (rx_mode == 1)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= ($urandom_range(0, 3) == 0);
    end

    // ---------------------------------------------------------------- drivers
    task automatic set_clip(logic [1:0] axis, longint lo, longint hi, int attrs,
                            longint nz);
        logic [15:0] vals [5];
        vals = '{16'(axis), 16'(lo), 16'(hi), 16'(attrs), 16'(nz)};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        plane_axis = axis;
        slab_lo    = longint'($signed(16'(lo)));
        slab_hi    = longint'($signed(16'(hi)));
        attr_used  = attrs & 7;
        near_z     = nz & 16'hFFFF;
    endtask

    task automatic send_vertex(vec_t v, bit closing_vtx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = src_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {24'(v[6]), 24'(v[5]), 24'(v[4]), 24'(v[3]), 24'(v[2]),
                          16'(v[1]), 16'(v[0])};
        s_axis_tlast  <= closing_vtx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_clip(v, closing_vtx);
        items_sent++;
    endtask

    // hold the source, then let the block finish whatever it still works on
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic longint pick(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic longint pick_coord(longint bound_a, longint bound_b,
                                          longint lim_lo, longint lim_hi);
        longint v;
        case ($urandom_range(0, 9))
            0:       v = lim_lo;
            1:       v = lim_hi;
            2:       v = bound_a;
            3:       v = bound_b;
            4, 5:    v = pick(lim_lo, lim_hi);
            default: v = pick(bound_a - 600, bound_b + 600);
        endcase
        if (v < lim_lo)
            v = lim_lo;
        if (v > lim_hi)
            v = lim_hi;
        return v;
    endfunction

    function automatic vec_t random_vertex();
        vec_t v;
        v[0] = pick_coord(slab_lo, slab_hi, -32768, 32767);
        v[1] = pick_coord(slab_lo, slab_hi, -32768, 32767);
        v[2] = pick_coord(near_z, near_z, -8388608, 8388607);
        for (int i = 3; i < 7; i++)
            v[i] = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ?
                   longint'(8388607) : longint'(-8388608)) : pick(-8388608, 8388607);
        return v;
    endfunction

    task automatic send_polygon(int n);
        vec_t pts [$];
        for (int i = 0; i < n; i++)
            pts.push_back(random_vertex());
        foreach (pts[i])
            send_vertex(pts[i], 1'b0);
        send_vertex(pts[0], 1'b1);
    endtask

    function automatic vec_t mk(longint x, longint y, longint z, longint a);
        vec_t v;
        v = '{x, y, z, a, -a, a >>> 3, 8388607 - a};
        return v;
    endfunction

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        vec_t p0;
        src_gaps = 1'b0;
        // lone closing vertex: no edge
        send_vertex(mk(100, 100, 50, 1000), 1'b1);
        // triangle fully inside the x slab
        p0 = mk(10, 20, 30, 8388607);
        send_vertex(p0, 1'b0);
        send_vertex(mk(300, 40, 60, -8388608), 1'b0);
        send_vertex(mk(150, 200, 90, 0), 1'b0);
        send_vertex(p0, 1'b1);
        // edge crossing both bounds, vertex on a bound, equal x, extremes
        p0 = mk(-32768, -32768, -8388608, -8388608);
        send_vertex(p0, 1'b0);
        send_vertex(mk(32767, 32767, 8388607, 8388607), 1'b0);
        send_vertex(mk(319, 0, 5, 77), 1'b0);
        send_vertex(mk(319, 500, 9, -77), 1'b0);
        send_vertex(mk(0, -5, 1, 12345), 1'b0);
        send_vertex(p0, 1'b1);
        // fully clipped polygon
        p0 = mk(-500, 0, 0, 1);
        send_vertex(p0, 1'b0);
        send_vertex(mk(-10, 10, 0, 2), 1'b0);
        send_vertex(mk(-300, 90, 0, 3), 1'b0);
        send_vertex(p0, 1'b1);
        wait_idle();
        // y slab with no attributes
        set_clip(AXIS_Y, -100, 100, 0, 16);
        p0 = mk(5, -32768, 100, 4444);
        send_vertex(p0, 1'b0);
        send_vertex(mk(-9, 32767, -100, -4444), 1'b0);
        send_vertex(p0, 1'b1);
        wait_idle();
        // near plane, attribute count above four
        set_clip(2'd2, 0, 0, 7, 16);
        p0 = mk(-32768, 32767, -8388608, 8388607);
        send_vertex(p0, 1'b0);
        send_vertex(mk(32767, -32768, 8388607, -8388608), 1'b0);
        send_vertex(mk(0, 0, 16, 0), 1'b0);
        send_vertex(p0, 1'b1);
        wait_idle();
        // axis mode three behaves as near z
        set_clip(2'd3, 0, 0, 2, 65535);
        p0 = mk(1, 2, 0, 100);
        send_vertex(p0, 1'b0);
        send_vertex(mk(3, 4, 70000, 200), 1'b0);
        send_vertex(p0, 1'b1);
        wait_idle();
    endtask

    task automatic test_random();
        src_gaps = 1'b1;
        while (items_sent < 230)
        begin
            case ($urandom_range(0, 5))
                0:       set_clip(AXIS_X, -32768, 32767, $urandom_range(0, 7),
                                  $urandom_range(0, 65535));
                1:       set_clip(2'd2, 0, 0, $urandom_range(0, 7),
                                  ($urandom_range(0, 1) != 0) ? 0 : 65535);
                2:       set_clip(2'd2, 0, 0, $urandom_range(0, 7),
                                  $urandom_range(0, 65535));
                default: set_clip(2'($urandom_range(0, 3)), pick(-1000, 200),
                                  pick(-100, 1200), $urandom_range(0, 7),
                                  $urandom_range(0, 65535));
            endcase
            src_gaps = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 4; k++)
            begin
                // mostly whole polygons, now and then a stray or short one
                if ($urandom_range(0, 7) == 0)
                    send_vertex(random_vertex(), 1'b1);
                else
                    send_polygon($urandom_range(($urandom_range(0, 5) == 0) ? 1 : 3, 8));
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        set_clip(AXIS_X, 0, 319, 4, 16);
        src_gaps      = 1'b0;
        stall_request = 1'b1;
        send_polygon(8);
        wait_idle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cycles        = 0;
        errors        = 0;
        items_sent    = 0;
        burst_left    = 0;
        stall_request = 1'b0;
        stall_left    = 0;
        rx_mode       = 0;
        open_edge     = 1'b0;
        poly_count    = 0;
        last_vtx      = '{0, 0, 0, 0, 0, 0, 0};
        first_emitted = '{0, 0, 0, 0, 0, 0, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_clip(AXIS_X, 0, 319, 4, 16);
        test_directed();
        test_backpressure();
        test_random();
        wait_idle();
        if (errors == 0 && pending_beats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
